[sv/ssm_pkg.sv]
// Shared types and constants for the sorted squares merge block.
package ssm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SQUARE_W      = 31;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SQUARE_W-1:0] t_square;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_LO,
        S_SQ_LO,
        S_SQ_HI,
        S_CMP,
        S_SQ_STEP,
        S_OUT_RD,
        S_OUT
    } t_state;

endpackage

[sv/ssm_if.sv]
// Valid/ready channel interfaces for the sorted squares merge block.
interface ssm_in_if;
    logic             valid;
    logic             ready;
    ssm_pkg::t_sample sample;
    logic             final_item;

    modport source (output valid, output sample, output final_item, input ready);
    modport sink   (input valid, input sample, input final_item, output ready);
endinterface

interface ssm_out_if;
    logic             valid;
    logic             ready;
    ssm_pkg::t_square square;
    logic             final_result;
    logic             overflow;

    modport source (output valid, output square, output final_result, output overflow,
                    input ready);
    modport sink   (input valid, input square, input final_result, input overflow,
                    output ready);
endinterface

[sv/sorted_squares_merge.sv]
// Top level: collects a sorted set, merges squares from both ends, streams them out ascending.
// Load: one cycle per input item; the block is ready only while collecting a set.
// Merge: after the final item, S_RD_LO..S_SQ_HI fetch and square both ends; then S_CMP places
//   each square and S_SQ_STEP squares the next (one shared squarer, one value-memory read port).
// Output: S_OUT_RD primes the square-memory read, then one square per cycle while taken.
// Reset (sync, i_rst_n low): collect again, clear count and drop flag; stores keep contents.
module sorted_squares_merge #(
    parameter int MAX_ITEMS = ssm_pkg::MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssm_in_if.sink    i_in_ch,
    ssm_out_if.source o_out_ch
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = ssm_pkg::SAMPLE_W;
    localparam int QW = ssm_pkg::SQUARE_W;

    // Value and square stores: one write and one registered read port each.
    ssm_pkg::t_sample r_val_mem [MAX_ITEMS];
    ssm_pkg::t_square r_sq_mem  [MAX_ITEMS];

    ssm_pkg::t_state  r_state, n_state;

    logic [CW-1:0]    r_count;     // values stored in the current set
    logic             r_drop;      // an item of this set was dropped
    logic [AW-1:0]    r_lo, r_hi;  // merge pointers into the value store
    logic [CW-1:0]    r_left;      // squares still to place
    logic [AW-1:0]    r_idx;       // output read pointer
    logic             r_side;      // 1: left pointer moved last step

    ssm_pkg::t_sample r_rd;        // value-store read data
    ssm_pkg::t_square r_sq_a;      // square at the left end
    ssm_pkg::t_square r_sq_b;      // square at the right end
    ssm_pkg::t_square r_sq_rd;     // square-store read data, drives the output

    logic             in_fire;
    logic             out_fire;
    logic             fits;
    logic [CW-1:0]    count_next;
    logic             take_left;
    ssm_pkg::t_square pick;
    logic [AW-1:0]    val_raddr;
    logic             sq_ren;
    logic [AW-1:0]    sq_raddr;
    logic             out_last;

    // Shared squaring unit: magnitude of a 16-bit signed value, squared.
    logic [SW-1:0]    mag;
    logic [2*SW-1:0]  prod;
    ssm_pkg::t_square sq_res;

    assign mag    = r_rd[SW-1] ? (~r_rd + SW'(1)) : r_rd;
    assign prod   = mag * mag;
    assign sq_res = prod[QW-1:0];

    assign in_fire    = i_in_ch.valid && i_in_ch.ready;
    assign out_fire   = o_out_ch.valid && o_out_ch.ready;
    assign fits       = (r_count < CW'(MAX_ITEMS));
    assign count_next = fits ? (r_count + CW'(1)) : r_count;

    // Larger end square wins; ties take the left end.
    assign take_left = (r_sq_a >= r_sq_b);
    assign pick      = take_left ? r_sq_a : r_sq_b;

    assign out_last  = ({{(CW-AW){1'b0}}, r_idx} == (r_count - CW'(1)));

    assign i_in_ch.ready         = (r_state == ssm_pkg::S_LOAD);
    assign o_out_ch.valid        = (r_state == ssm_pkg::S_OUT);
    assign o_out_ch.square       = r_sq_rd;
    assign o_out_ch.final_result = out_last;
    assign o_out_ch.overflow     = r_drop;

    // Sequencer: next state and read-port addressing.
    always_comb begin
        n_state   = r_state;
        val_raddr = r_lo;
        sq_ren    = 1'b0;
        sq_raddr  = r_idx;
        unique case (r_state)
            ssm_pkg::S_LOAD: begin
                if (in_fire && i_in_ch.final_item) begin
                    n_state = ssm_pkg::S_RD_LO;
                end
            end
            ssm_pkg::S_RD_LO: begin
                val_raddr = r_lo;
                n_state   = ssm_pkg::S_SQ_LO;
            end
            ssm_pkg::S_SQ_LO: begin
                val_raddr = r_hi;
                n_state   = ssm_pkg::S_SQ_HI;
            end
            ssm_pkg::S_SQ_HI: begin
                n_state = ssm_pkg::S_CMP;
            end
            ssm_pkg::S_CMP: begin
                // fetch the value that replaces the consumed end
                val_raddr = take_left ? (r_lo + AW'(1)) : (r_hi - AW'(1));
                if (r_left == CW'(1)) begin
                    n_state = ssm_pkg::S_OUT_RD;
                end else begin
                    n_state = ssm_pkg::S_SQ_STEP;
                end
            end
            ssm_pkg::S_SQ_STEP: begin
                n_state = ssm_pkg::S_CMP;
            end
            ssm_pkg::S_OUT_RD: begin
                sq_ren   = 1'b1;
                sq_raddr = r_idx;
                n_state  = ssm_pkg::S_OUT;
            end
            ssm_pkg::S_OUT: begin
                if (out_fire) begin
                    if (out_last) begin
                        n_state = ssm_pkg::S_LOAD;
                    end else begin
                        // prefetch the next square so one goes out per cycle while taken
                        sq_ren   = 1'b1;
                        sq_raddr = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ssm_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Control counters and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_left  <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_idx   <= '0;
            r_side  <= 1'b0;
        end else begin
            unique case (r_state)
                ssm_pkg::S_LOAD: begin
                    if (in_fire) begin
                        r_count <= count_next;
                        if (!fits) begin
                            r_drop <= 1'b1;
                        end
                        // arm the merge over the whole stored set
                        r_lo   <= '0;
                        r_hi   <= AW'(count_next - CW'(1));
                        r_left <= count_next;
                        r_idx  <= '0;
                    end
                end
                ssm_pkg::S_CMP: begin
                    r_left <= r_left - CW'(1);
                    r_side <= take_left;
                    if (take_left) begin
                        r_lo <= r_lo + AW'(1);
                    end else begin
                        r_hi <= r_hi - AW'(1);
                    end
                end
                ssm_pkg::S_OUT: begin
                    if (out_fire) begin
                        if (out_last) begin
                            // set done: start a fresh one
                            r_count <= '0;
                            r_drop  <= 1'b0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Squarer results into the end registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ssm_pkg::S_SQ_LO: r_sq_a <= sq_res;
            ssm_pkg::S_SQ_HI: r_sq_b <= sq_res;
            ssm_pkg::S_SQ_STEP: begin
                if (r_side) begin
                    r_sq_a <= sq_res;
                end else begin
                    r_sq_b <= sq_res;
                end
            end
            default: begin
            end
        endcase
    end

    // Value store: write on an accepted item that fits, read every cycle.
    always_ff @(posedge i_clk) begin
        if ((r_state == ssm_pkg::S_LOAD) && in_fire && fits) begin
            r_val_mem[r_count[AW-1:0]] <= i_in_ch.sample;
        end
        r_rd <= r_val_mem[val_raddr];
    end

    // Square store: fill from the top down during the merge, read ascending.
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::S_CMP) begin
            r_sq_mem[AW'(r_left - CW'(1))] <= pick;
        end
        if (sq_ren) begin
            r_sq_rd <= r_sq_mem[sq_raddr];
        end
    end

endmodule
